>>> hdl/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

  localparam int MAX_ORDER  = 15;
  localparam int POOL_PAGES = 65536;
  localparam int PAGE_W     = 16;
  localparam int ORD_W      = 4;
  localparam int TP_W       = 16;
  localparam int LIMIT_W    = 17;

  localparam logic [1:0] MARK_NONE = 2'b00;
  localparam logic [1:0] MARK_HEAD = 2'b01;
  localparam logic [1:0] MARK_BUSY = 2'b11;

  localparam logic [1:0] REQ_ALLOC       = 2'd0;
  localparam logic [1:0] REQ_ALLOC_BELOW = 2'd1;
  localparam logic [1:0] REQ_FREE        = 2'd2;
  localparam logic [1:0] REQ_SPLIT       = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [PAGE_W-1:0] nl_ra;
    logic              nl_we;
    logic [PAGE_W-1:0] nl_wa;
    logic [PAGE_W-1:0] nl_wd;
    logic [PAGE_W-1:0] pl_ra;
    logic              pl_we;
    logic [PAGE_W-1:0] pl_wa;
    logic [PAGE_W-1:0] pl_wd;
    logic [PAGE_W-1:0] po_ra;
    logic              po_we;
    logic [PAGE_W-1:0] po_wa;
    logic [ORD_W-1:0]  po_wd;
    logic [PAGE_W-1:0] pm_ra;
    logic              pm_we;
    logic [PAGE_W-1:0] pm_wa;
    logic [1:0]        pm_wd;
    logic [PAGE_W-1:0] tp_ra;
    logic              tp_we;
    logic [PAGE_W-1:0] tp_wa;
    logic [TP_W-1:0]   tp_wd;
    logic [PAGE_W-1:0] pb_ra;
    logic              pb_we;
    logic [PAGE_W-1:0] pb_wa;
    logic              pb_wd;
  } mem_cmd_t;

  typedef struct packed {
    logic [PAGE_W-1:0] nl_q;
    logic [PAGE_W-1:0] pl_q;
    logic [ORD_W-1:0]  po_q;
    logic [1:0]        pm_q;
    logic [TP_W-1:0]   tp_q;
    logic              pb_q;
    logic              clearing;
  } mem_sts_t;

  function automatic logic [PAGE_W:0] one_shift(input logic [ORD_W-1:0] ord);
    return {{PAGE_W{1'b0}}, 1'b1} << ord;
  endfunction

  // Page that holds the pair bit of the block at p; bit PAGE_W set means none.
  function automatic logic [PAGE_W:0] pair_at(input logic [PAGE_W-1:0] p,
                                              input logic [TP_W-1:0] tp,
                                              input logic [ORD_W-1:0] ord);
    logic [PAGE_W:0] r;
    r = tp[0] ? {1'b0, p} : {1'b0, p} + one_shift(ord);
    if (tp == TP_W'(1)) begin
      r[PAGE_W] = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/bpa_ram.sv
`default_nettype none
module bpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/bpa_datapath.sv
`default_nettype none
module bpa_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bpa_pkg::mem_cmd_t cmd,
  output bpa_pkg::mem_sts_t     sts
);
  import bpa_pkg::*;

  logic [PAGE_W-1:0] clr_addr;
  logic              clearing;
  logic              head;
  logic [PAGE_W-1:0] link_init;

  // After reset every page is rewritten; the initial roots link to each other.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_addr <= clr_addr + PAGE_W'(1);
      if (clr_addr == PAGE_W'(POOL_PAGES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign head      = (clr_addr[MAX_ORDER-1:0] == '0);
  assign link_init = head ? clr_addr + PAGE_W'(1 << MAX_ORDER) : '0;
  assign sts.clearing = clearing;

  bpa_ram #(.WIDTH(PAGE_W), .DEPTH(POOL_PAGES)) u_next (
    .clk(clk), .we(clearing | cmd.nl_we),
    .waddr(clearing ? clr_addr : cmd.nl_wa),
    .wdata(clearing ? link_init : cmd.nl_wd),
    .raddr(cmd.nl_ra), .rdata(sts.nl_q));

  bpa_ram #(.WIDTH(PAGE_W), .DEPTH(POOL_PAGES)) u_prev (
    .clk(clk), .we(clearing | cmd.pl_we),
    .waddr(clearing ? clr_addr : cmd.pl_wa),
    .wdata(clearing ? link_init : cmd.pl_wd),
    .raddr(cmd.pl_ra), .rdata(sts.pl_q));

  bpa_ram #(.WIDTH(ORD_W), .DEPTH(POOL_PAGES)) u_order (
    .clk(clk), .we(clearing | cmd.po_we),
    .waddr(clearing ? clr_addr : cmd.po_wa),
    .wdata(clearing ? (head ? ORD_W'(MAX_ORDER) : '0) : cmd.po_wd),
    .raddr(cmd.po_ra), .rdata(sts.po_q));

  bpa_ram #(.WIDTH(2), .DEPTH(POOL_PAGES)) u_marks (
    .clk(clk), .we(clearing | cmd.pm_we),
    .waddr(clearing ? clr_addr : cmd.pm_wa),
    .wdata(clearing ? (head ? MARK_HEAD : MARK_NONE) : cmd.pm_wd),
    .raddr(cmd.pm_ra), .rdata(sts.pm_q));

  bpa_ram #(.WIDTH(TP_W), .DEPTH(POOL_PAGES)) u_tree (
    .clk(clk), .we(clearing | cmd.tp_we),
    .waddr(clearing ? clr_addr : cmd.tp_wa),
    .wdata(clearing ? (head ? TP_W'(1) : '0) : cmd.tp_wd),
    .raddr(cmd.tp_ra), .rdata(sts.tp_q));

  bpa_ram #(.WIDTH(1), .DEPTH(POOL_PAGES)) u_pair (
    .clk(clk), .we(clearing | cmd.pb_we),
    .waddr(clearing ? clr_addr : cmd.pb_wa),
    .wdata(clearing ? 1'b0 : cmd.pb_wd),
    .raddr(cmd.pb_ra), .rdata(sts.pb_q));
endmodule
`default_nettype wire

>>> hdl/bpa_ctrl.sv
`default_nettype none
module bpa_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [23:0]                s_axis_tdata,
  input  wire logic [1:0]                 s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic      [15:0]                m_axis_tdata,
  output logic      [1:0]                 m_axis_tuser,
  input  wire logic                       cfg_wr_en,
  input  wire logic [bpa_pkg::LIMIT_W-1:0] cfg_wr_data,
  output bpa_pkg::mem_cmd_t               cmd,
  input  wire bpa_pkg::mem_sts_t          sts
);
  import bpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_A_SCAN, S_W_CHK, S_W_NXT, S_T_START, S_T_TP, S_T_FLIP,
    S_T_LOOP, S_T_SPLW, S_T_RFLIP, S_T_END, S_B_CHK, S_S_WR, S_F_LOOP, S_F_GET,
    S_F_MERGE, S_F_END, S_F_FIN, S_RM_RD, S_RM_LINK, S_RM_SELF, S_PU_START,
    S_PU_T, S_PU_H, S_FL_RD, S_FL_WR, S_DONE
  } state_t;

  state_t             state, ret;
  logic [1:0]         typ;
  logic [ORD_W-1:0]   want;
  logic [PAGE_W-1:0]  blk;
  logic [ORD_W:0]     o;
  logic [PAGE_W-1:0]  q, r, l;
  logic [TP_W-1:0]    tpq, tpr;
  logic [PAGE_W-1:0]  lh [MAX_ORDER+1];
  logic [MAX_ORDER:0] lv;
  logic [ORD_W-1:0]   rm_o, pu_o;
  logic [PAGE_W-1:0]  rm_p, pu_p, fr;
  logic               fbit;
  logic [LIMIT_W-1:0] limit_page;
  logic [1:0]         res_st;
  logic [PAGE_W-1:0]  res_idx;

  logic [PAGE_W:0]    split_r, fl_q, fl_r, bud, half_r;
  logic               below;

  assign split_r = {1'b0, blk} + one_shift(sts.po_q - ORD_W'(1));
  assign half_r  = {1'b0, q} + one_shift(ORD_W'(o - (ORD_W+1)'(1)));
  assign fl_q    = pair_at(q, tpq, o[ORD_W-1:0]);
  assign fl_r    = pair_at(r, tpr, o[ORD_W-1:0]);
  assign bud     = tpq[0] ? {1'b0, q} - one_shift(o[ORD_W-1:0])
                          : {1'b0, q} + one_shift(o[ORD_W-1:0]);
  assign below   = ({1'b0, q} < limit_page);
  assign s_axis_tready = (state == S_IDLE) && !sts.clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ret           <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      limit_page    <= LIMIT_W'(POOL_PAGES);
      lv            <= {1'b1, {MAX_ORDER{1'b0}}};
      for (int i = 0; i <= MAX_ORDER; i++) begin
        lh[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        limit_page <= cfg_wr_data;
      end
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            typ   <= s_axis_tuser;
            want  <= s_axis_tdata[3:0];
            blk   <= s_axis_tdata[19:4];
            state <= S_START;
          end
        end
        S_START: begin
          if (typ == REQ_ALLOC || typ == REQ_ALLOC_BELOW) begin
            o <= {1'b0, want};
            if (32'(want) > MAX_ORDER) begin
              res_st <= ST_NONE;
              state  <= S_DONE;
            end else begin
              state <= S_A_SCAN;
            end
          end else begin
            state <= S_B_CHK;
          end
        end
        S_A_SCAN: begin
          if (32'(o) > MAX_ORDER) begin
            res_st <= ST_NONE;
            state  <= S_DONE;
          end else if (!lv[o[ORD_W-1:0]]) begin
            o <= o + (ORD_W+1)'(1);
          end else begin
            q     <= lh[o[ORD_W-1:0]];
            state <= (typ == REQ_ALLOC) ? S_T_START : S_W_CHK;
          end
        end
        S_W_CHK: begin
          state <= below ? S_T_START : S_W_NXT;
        end
        S_W_NXT: begin
          q <= sts.nl_q;
          if (sts.nl_q == lh[o[ORD_W-1:0]]) begin
            o     <= o + (ORD_W+1)'(1);
            state <= S_A_SCAN;
          end else begin
            state <= S_W_CHK;
          end
        end
        S_T_START: state <= S_T_TP;
        S_T_TP: begin
          tpq   <= sts.tp_q;
          rm_o  <= o[ORD_W-1:0];
          rm_p  <= q;
          ret   <= S_T_FLIP;
          state <= S_RM_RD;
        end
        S_T_FLIP: begin
          fr    <= fl_q[PAGE_W-1:0];
          ret   <= S_T_LOOP;
          state <= fl_q[PAGE_W] ? S_T_LOOP : S_FL_RD;
        end
        S_T_LOOP: begin
          if (o > {1'b0, want}) begin
            r     <= half_r[PAGE_W-1:0];
            tpr   <= {tpq[TP_W-2:0], 1'b1};
            tpq   <= {tpq[TP_W-2:0], 1'b0};
            o     <= o - (ORD_W+1)'(1);
            state <= S_T_SPLW;
          end else begin
            state <= S_T_END;
          end
        end
        S_T_SPLW: begin
          pu_o  <= o[ORD_W-1:0];
          pu_p  <= r;
          ret   <= S_T_RFLIP;
          state <= S_PU_START;
        end
        S_T_RFLIP: begin
          fr    <= fl_r[PAGE_W-1:0];
          ret   <= S_T_LOOP;
          state <= fl_r[PAGE_W] ? S_T_LOOP : S_FL_RD;
        end
        S_T_END: begin
          res_st  <= ST_OK;
          res_idx <= q;
          state   <= S_DONE;
        end
        S_B_CHK: begin
          if (sts.pm_q != MARK_BUSY) begin
            res_st <= ST_INVALID;
            state  <= S_DONE;
          end else if (typ == REQ_FREE) begin
            q     <= blk;
            o     <= {1'b0, sts.po_q};
            tpq   <= sts.tp_q;
            state <= S_F_LOOP;
          end else if (sts.po_q == '0) begin
            res_st <= ST_NONE;
            state  <= S_DONE;
          end else if (split_r[PAGE_W]) begin
            res_st <= ST_INVALID;
            state  <= S_DONE;
          end else begin
            r     <= split_r[PAGE_W-1:0];
            tpq   <= {sts.tp_q[TP_W-2:0], 1'b0};
            o     <= {1'b0, sts.po_q - ORD_W'(1)};
            state <= S_S_WR;
          end
        end
        S_S_WR: begin
          res_st  <= ST_OK;
          res_idx <= r;
          state   <= S_DONE;
        end
        S_F_LOOP: begin
          if (32'(o) < MAX_ORDER && !fl_q[PAGE_W]) begin
            fr    <= fl_q[PAGE_W-1:0];
            ret   <= S_F_GET;
            state <= S_FL_RD;
          end else begin
            state <= S_F_END;
          end
        end
        S_F_GET: begin
          if (fbit || bud[PAGE_W]) begin
            state <= S_F_END;
          end else begin
            rm_o  <= o[ORD_W-1:0];
            rm_p  <= bud[PAGE_W-1:0];
            r     <= tpq[0] ? q : bud[PAGE_W-1:0];
            l     <= tpq[0] ? bud[PAGE_W-1:0] : q;
            ret   <= S_F_MERGE;
            state <= S_RM_RD;
          end
        end
        S_F_MERGE: begin
          q     <= l;
          tpq   <= {1'b0, tpq[TP_W-1:1]};
          o     <= o + (ORD_W+1)'(1);
          state <= S_F_LOOP;
        end
        S_F_END: begin
          pu_o  <= o[ORD_W-1:0];
          pu_p  <= q;
          ret   <= S_F_FIN;
          state <= S_PU_START;
        end
        S_F_FIN: begin
          res_st <= ST_OK;
          state  <= S_DONE;
        end
        S_RM_RD: state <= S_RM_LINK;
        S_RM_LINK: begin
          if (lv[rm_o] && lh[rm_o] == rm_p) begin
            if (sts.nl_q == rm_p) begin
              lv[rm_o] <= 1'b0;
            end else begin
              lh[rm_o] <= sts.nl_q;
            end
          end
          state <= S_RM_SELF;
        end
        S_RM_SELF: state <= ret;
        S_PU_START: begin
          if (!lv[pu_o]) begin
            lv[pu_o] <= 1'b1;
            lh[pu_o] <= pu_p;
            state    <= ret;
          end else begin
            state <= S_PU_T;
          end
        end
        S_PU_T: state <= S_PU_H;
        S_PU_H: state <= ret;
        S_FL_RD: state <= S_FL_WR;
        S_FL_WR: begin
          fbit  <= ~sts.pb_q;
          state <= ret;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= res_st;
            m_axis_tdata  <= (res_st == ST_OK && typ != REQ_FREE) ? res_idx : '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_START: begin
        cmd.pm_ra = blk;
        cmd.po_ra = blk;
        cmd.tp_ra = blk;
      end
      S_W_CHK:   cmd.nl_ra = q;
      S_T_START: cmd.tp_ra = q;
      S_T_SPLW: begin
        cmd.tp_we = 1'b1; cmd.tp_wa = r; cmd.tp_wd = tpr;
        cmd.po_we = 1'b1; cmd.po_wa = r; cmd.po_wd = o[ORD_W-1:0];
        cmd.pm_we = 1'b1; cmd.pm_wa = r; cmd.pm_wd = MARK_HEAD;
      end
      S_T_END: begin
        cmd.pm_we = 1'b1; cmd.pm_wa = q; cmd.pm_wd = MARK_BUSY;
        cmd.po_we = 1'b1; cmd.po_wa = q; cmd.po_wd = want;
        cmd.tp_we = 1'b1; cmd.tp_wa = q; cmd.tp_wd = tpq;
      end
      S_B_CHK: begin
        // The right half of a split is written as soon as the checks pass.
        if (typ == REQ_SPLIT && sts.pm_q == MARK_BUSY && sts.po_q != '0
            && !split_r[PAGE_W]) begin
          cmd.pm_we = 1'b1; cmd.pm_wa = split_r[PAGE_W-1:0]; cmd.pm_wd = MARK_BUSY;
          cmd.tp_we = 1'b1; cmd.tp_wa = split_r[PAGE_W-1:0];
          cmd.tp_wd = {sts.tp_q[TP_W-2:0], 1'b1};
          cmd.po_we = 1'b1; cmd.po_wa = split_r[PAGE_W-1:0];
          cmd.po_wd = sts.po_q - ORD_W'(1);
        end
      end
      S_S_WR: begin
        cmd.tp_we = 1'b1; cmd.tp_wa = blk; cmd.tp_wd = tpq;
        cmd.po_we = 1'b1; cmd.po_wa = blk; cmd.po_wd = o[ORD_W-1:0];
      end
      S_F_MERGE: begin
        cmd.pm_we = 1'b1; cmd.pm_wa = r; cmd.pm_wd = MARK_NONE;
        cmd.po_we = 1'b1; cmd.po_wa = r; cmd.po_wd = '0;
        cmd.tp_we = 1'b1; cmd.tp_wa = r; cmd.tp_wd = '0;
      end
      S_F_END: begin
        cmd.pm_we = 1'b1; cmd.pm_wa = q; cmd.pm_wd = MARK_HEAD;
        cmd.po_we = 1'b1; cmd.po_wa = q; cmd.po_wd = o[ORD_W-1:0];
        cmd.tp_we = 1'b1; cmd.tp_wa = q; cmd.tp_wd = tpq;
      end
      S_RM_RD: begin
        cmd.nl_ra = rm_p;
        cmd.pl_ra = rm_p;
      end
      S_RM_LINK: begin
        cmd.nl_we = 1'b1; cmd.nl_wa = sts.pl_q; cmd.nl_wd = sts.nl_q;
        cmd.pl_we = 1'b1; cmd.pl_wa = sts.nl_q; cmd.pl_wd = sts.pl_q;
      end
      S_RM_SELF: begin
        cmd.nl_we = 1'b1; cmd.nl_wa = rm_p; cmd.nl_wd = rm_p;
        cmd.pl_we = 1'b1; cmd.pl_wa = rm_p; cmd.pl_wd = rm_p;
      end
      S_PU_START: begin
        if (!lv[pu_o]) begin
          cmd.nl_we = 1'b1; cmd.nl_wa = pu_p; cmd.nl_wd = pu_p;
          cmd.pl_we = 1'b1; cmd.pl_wa = pu_p; cmd.pl_wd = pu_p;
        end else begin
          cmd.pl_ra = lh[pu_o];
        end
      end
      S_PU_T: begin
        cmd.nl_we = 1'b1; cmd.nl_wa = sts.pl_q; cmd.nl_wd = pu_p;
        cmd.pl_we = 1'b1; cmd.pl_wa = pu_p;     cmd.pl_wd = sts.pl_q;
      end
      S_PU_H: begin
        cmd.nl_we = 1'b1; cmd.nl_wa = pu_p;     cmd.nl_wd = lh[pu_o];
        cmd.pl_we = 1'b1; cmd.pl_wa = lh[pu_o]; cmd.pl_wd = pu_p;
      end
      S_FL_RD: cmd.pb_ra = fr;
      S_FL_WR: begin
        cmd.pb_we = 1'b1; cmd.pb_wa = fr; cmd.pb_wd = ~sts.pb_q;
      end
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/buddy_page_allocator_top.sv
// Buddy page allocator over 65536 pages, orders 0 to 15.
// Request channel s_axis: tuser carries the request kind (allocate, allocate
// below limit_page, free, split); tdata carries the order and the block head.
// Response channel m_axis: tuser carries the status, tdata the result page.
// One response follows every request transfer, in order.
// Requests are handled one at a time by a state machine that drives six
// page memories, each with one write port and one registered read port.
// An allocation takes the first nonempty order at or above the wanted one and
// splits its head level by level; in the below-limit mode it walks each list
// for a block under limit_page. A free merges with its buddy level by level.
// The next request is taken once the response is registered.
// limit_page is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// After reset the block rewrites every page entry once with s_axis_tready
// low; the pool then holds two free blocks of order 15.
// The response sits in an output register; a stalled receiver holds it there
// while the next request is already accepted and worked on, and that next
// response waits until the held one is transferred.
`default_nettype none
module buddy_page_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // order [3:0], block_index [19:4]
  input  wire logic [1:0]  s_axis_tuser,   // req_type [1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // result_index [15:0]
  output logic      [1:0]  m_axis_tuser,   // status [1:0]
  input  wire logic        cfg_wr_en,
  input  wire logic [16:0] cfg_wr_data
);
  import bpa_pkg::*;

  mem_cmd_t cmd;
  mem_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .cmd(cmd), .sts(sts));

  bpa_datapath u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts));
endmodule
`default_nettype wire
